FILE: rtl/core/bgc_pkg.sv
// Shared types, codes and reset constants of the button gesture classifier.
`timescale 1ns / 1ps

package bgc_pkg;

    localparam int NUM_BUTTONS_DEF = 4;
    localparam int TIME_BITS_DEF   = 32;
    localparam int CFG_W           = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int NOW_W           = 32;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST = CFG_W'(1000000);
    localparam logic [CFG_W-1:0] HOLD_RST       = CFG_W'(500000);
    localparam logic [CFG_W-1:0] DOUBLE_RST     = CFG_W'(500000);

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_INIT   = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS = 2'd0,
        CFG_HOLD       = 2'd1,
        CFG_DOUBLE     = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        EV_PRESS       = 3'd0,
        EV_RELEASE     = 3'd1,
        EV_CLICK       = 3'd2,
        EV_DOUBLE      = 3'd3,
        EV_LONG_CLICK  = 3'd4,
        EV_LONG_PRESS  = 3'd5,
        EV_HOLD        = 3'd6
    } t_event;

    typedef struct packed {
        logic [CFG_W-1:0] long_press_time;
        logic [CFG_W-1:0] hold_time;
        logic [CFG_W-1:0] double_click_time;
    } t_cfg;

    // Events one button raises for one item, plus its pressed state before and after.
    typedef struct packed {
        logic [1:0] cnt;
        t_event     code0;
        t_event     code1;
        t_event     code2;
        logic       down_now;
        logic       down_next;
    } t_lane_ev;

endpackage

FILE: rtl/core/bgc_lane.sv
// One button lane: per-button state, timing compares and event classification.
`timescale 1ns / 1ps

module bgc_lane import bgc_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [1:0]           i_kind,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic                 i_pin,
    input  t_cfg                 i_cfg,
    output t_lane_ev             o_ev
);

    localparam int CW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    logic                 r_down, n_down;
    logic                 r_armed, n_armed;
    logic [TIME_BITS-1:0] r_press, n_press;
    logic [TIME_BITS-1:0] r_hold, n_hold;
    logic [TIME_BITS-1:0] r_rel, n_rel;

    logic [TIME_BITS-1:0] w_d_press, w_d_hold, w_d_rel;
    logic                 w_long, w_hold_due, w_dbl_gap, w_pressed;
    t_lane_ev             w_ev;

    // Wrapping differences, compared at the wider of time and register widths.
    assign w_d_press  = i_now - r_press;
    assign w_d_hold   = i_now - r_hold;
    assign w_d_rel    = r_press - r_rel;
    assign w_long     = CW'(w_d_press) > CW'(i_cfg.long_press_time);
    assign w_hold_due = CW'(w_d_hold) > CW'(i_cfg.hold_time);
    assign w_dbl_gap  = CW'(w_d_rel) < CW'(i_cfg.double_click_time);
    assign w_pressed  = ~i_pin;

    always_comb begin
        n_down  = r_down;
        n_armed = r_armed;
        n_press = r_press;
        n_hold  = r_hold;
        n_rel   = r_rel;
        w_ev.cnt   = 2'd0;
        w_ev.code0 = EV_PRESS;
        w_ev.code1 = EV_PRESS;
        w_ev.code2 = EV_PRESS;
        case (t_kind'(i_kind))
            KIND_TICK: begin
                if (r_down && w_long) begin
                    if (r_press == r_hold) begin
                        w_ev.cnt   = 2'd1;
                        w_ev.code0 = EV_LONG_PRESS;
                        n_hold     = i_now;
                    end else if (w_hold_due) begin
                        w_ev.cnt   = 2'd1;
                        w_ev.code0 = EV_HOLD;
                        n_hold     = i_now;
                    end
                end
            end
            KIND_SAMPLE: begin
                if (w_pressed != r_down) begin
                    n_down = w_pressed;
                    if (!w_pressed) begin
                        w_ev.code0 = EV_RELEASE;
                        n_rel      = i_now;
                        if (w_long) begin
                            w_ev.cnt   = 2'd2;
                            w_ev.code1 = EV_LONG_CLICK;
                            n_armed    = 1'b0;
                        end else if (w_dbl_gap) begin
                            w_ev.cnt   = r_armed ? 2'd3 : 2'd2;
                            w_ev.code1 = EV_CLICK;
                            w_ev.code2 = EV_DOUBLE;
                            n_armed    = 1'b0;
                        end else begin
                            w_ev.cnt   = 2'd2;
                            w_ev.code1 = EV_CLICK;
                            n_armed    = 1'b1;
                        end
                    end else begin
                        w_ev.cnt   = 2'd1;
                        w_ev.code0 = EV_PRESS;
                        n_press    = i_now;
                        n_hold     = i_now;
                    end
                end
            end
            KIND_INIT: begin
                n_down  = w_pressed;
                n_press = i_now;
                n_hold  = i_now;
                n_rel   = i_now;
            end
            default: begin
            end
        endcase
        w_ev.down_now  = r_down;
        w_ev.down_next = n_down;
    end

    assign o_ev = w_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down  <= 1'b0;
            r_armed <= 1'b1;
            r_press <= '0;
            r_hold  <= '0;
            r_rel   <= '0;
        end else if (i_load) begin
            r_down  <= n_down;
            r_armed <= n_armed;
            r_press <= n_press;
            r_hold  <= n_hold;
            r_rel   <= n_rel;
        end
    end

endmodule

FILE: rtl/core/bgc_merge.sv
// Merge stage: hold the lanes' events and issue them one beat at a time in button order.
`timescale 1ns / 1ps

module bgc_merge import bgc_pkg::*; #(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int IDX_W       = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_lane_ev               i_lanes [NUM_BUTTONS],
    output logic                   o_free,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [IDX_W-1:0]       o_button_index,
    output logic [2:0]             o_event_code,
    output logic [NUM_BUTTONS-1:0] o_pressed_mask,
    output logic                   o_last
);

    logic [NUM_BUTTONS-1:0] r_pend;
    logic [1:0]             r_slot;
    logic [1:0]             r_cnt  [NUM_BUTTONS];
    t_event                 r_code [NUM_BUTTONS][3];
    logic [NUM_BUTTONS-1:0] r_mask [NUM_BUTTONS];

    logic                   r_ovalid;
    logic [IDX_W-1:0]       r_obtn;
    t_event                 r_ocode;
    logic [NUM_BUTTONS-1:0] r_omask;
    logic                   r_olast;

    logic [NUM_BUTTONS-1:0] w_lmask [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] w_sel_oh;
    logic [IDX_W-1:0]       w_sel;
    logic                   w_emit, w_last_slot, w_final;

    // Button i sees lanes up to i already updated, higher lanes not yet.
    always_comb begin
        for (int l = 0; l < NUM_BUTTONS; l++) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                w_lmask[l][b] = (b <= l) ? i_lanes[b].down_next : i_lanes[b].down_now;
            end
        end
    end

    always_comb begin
        w_sel    = '0;
        w_sel_oh = '0;
        for (int l = NUM_BUTTONS - 1; l >= 0; l--) begin
            if (r_pend[l]) begin
                w_sel    = IDX_W'(l);
                w_sel_oh = NUM_BUTTONS'(1) << l;
            end
        end
    end

    assign w_emit      = (r_pend != '0) && (!r_ovalid || i_ready);
    assign w_last_slot = (r_slot + 2'd1) == r_cnt[w_sel];
    assign w_final     = w_last_slot && ((r_pend & ~w_sel_oh) == '0);
    assign o_free      = (r_pend == '0) || (w_emit && w_final);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_slot   <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_load) begin
                for (int l = 0; l < NUM_BUTTONS; l++) begin
                    r_pend[l] <= i_lanes[l].cnt != 2'd0;
                end
                r_slot <= 2'd0;
            end else if (w_emit) begin
                if (w_last_slot) begin
                    r_pend <= r_pend & ~w_sel_oh;
                    r_slot <= 2'd0;
                end else begin
                    r_slot <= r_slot + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int l = 0; l < NUM_BUTTONS; l++) begin
                r_cnt[l]     <= i_lanes[l].cnt;
                r_code[l][0] <= i_lanes[l].code0;
                r_code[l][1] <= i_lanes[l].code1;
                r_code[l][2] <= i_lanes[l].code2;
                r_mask[l]    <= w_lmask[l];
            end
        end
        if (w_emit) begin
            r_obtn  <= w_sel;
            r_ocode <= r_code[w_sel][r_slot];
            r_omask <= r_mask[w_sel];
            r_olast <= w_final;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_button_index = r_obtn;
    assign o_event_code   = r_ocode;
    assign o_pressed_mask = r_omask;
    assign o_last         = r_olast;

endmodule

FILE: rtl/core/button_gesture_classifier_top.sv
// Top level of the button gesture classifier: configuration, button lanes and merge stage.
`timescale 1ns / 1ps

// Turns timestamped pin samples and ticks for NUM_BUTTONS debounced push buttons
// (level low means pressed) into gesture events: press, release, click, double
// click, long click, long press and repeated hold. Every button has a lane of its
// own holding its pressed state and timestamps; all lanes judge an input beat in
// the same cycle, and the merge stage then issues their events one output beat per
// cycle while i_ready allows, lowest button first, with o_last marking the final
// event of the input beat. Each beat raises E events (0 to 3 per button, at most
// 3 * NUM_BUTTONS), which the merge stage moves one per cycle into the single
// output register, holding a waiting event back while i_ready is low. After a beat
// raising at most one event the next beat can be taken in the following cycle, and
// in general a new beat is taken in the same cycle the previous one's final event
// moves into the output register. Time differences wrap modulo 2^TIME_BITS.
// Configuration registers (long press time, hold spacing, double click gap, all in
// microseconds) are written through the cfg channel, which is always ready; write
// them only while the block is idle. Index 3 is ignored. No clearing pass runs
// after reset.
module button_gesture_classifier_top import bgc_pkg::*; #(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // item input
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_kind,
    input  logic [NOW_W-1:0]       i_now,
    input  logic [NUM_BUTTONS-1:0] i_pin_levels,
    // event output
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [((NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1)-1:0] o_button_index,
    output logic [2:0]             o_event_code,
    output logic [NUM_BUTTONS-1:0] o_pressed_mask,
    output logic                   o_last,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    t_cfg                 r_cfg;
    logic                 w_load;
    logic                 w_free;
    logic [TIME_BITS-1:0] w_now;
    t_lane_ev             w_lanes [NUM_BUTTONS];

    // Configuration: always ready, unknown indexes dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_time   <= LONG_PRESS_RST;
            r_cfg.hold_time         <= HOLD_RST;
            r_cfg.double_click_time <= DOUBLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_LONG_PRESS: r_cfg.long_press_time   <= i_cfg_data;
                CFG_HOLD:       r_cfg.hold_time         <= i_cfg_data;
                CFG_DOUBLE:     r_cfg.double_click_time <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Take a beat whenever the merge stage has room for its events.
    assign o_ready = w_free;
    assign w_load  = i_valid && w_free;
    assign w_now   = TIME_BITS'(i_now);

    // One lane per button; all of them judge the same beat in parallel.
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        bgc_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_load (w_load),
            .i_kind (i_kind),
            .i_now  (w_now),
            .i_pin  (i_pin_levels[g]),
            .i_cfg  (r_cfg),
            .o_ev   (w_lanes[g])
        );
    end

    // Serialise the lanes' findings in button order.
    bgc_merge #(
        .NUM_BUTTONS(NUM_BUTTONS),
        .IDX_W      (IDX_W)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_lanes       (w_lanes),
        .o_free        (w_free),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_button_index(o_button_index),
        .o_event_code  (o_event_code),
        .o_pressed_mask(o_pressed_mask),
        .o_last        (o_last)
    );

    // The event's own button bit reflects whether the event belongs to a held button.
    a_own_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pressed_mask[o_button_index] ==
                     (o_event_code == EV_PRESS || o_event_code == EV_LONG_PRESS ||
                      o_event_code == EV_HOLD)))
        else $error("pressed mask disagrees with event code");

    // A release is never final and is followed at once by its click or long click.
    a_release_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_event_code == EV_RELEASE) |->
            !o_last ##1 (o_valid && o_button_index == $past(o_button_index) &&
                         (o_event_code == EV_CLICK || o_event_code == EV_LONG_CLICK)))
        else $error("release not followed by its click");

    // After a click that is not final, the next event is another button's or its double click.
    a_double_after_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_event_code == EV_CLICK && !o_last) |=>
            (o_valid && (o_button_index != $past(o_button_index) ||
                         o_event_code == EV_DOUBLE)))
        else $error("click followed by wrong event of the same button");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the button gesture classifier: directed gestures, then random ones.
`timescale 1ns / 1ps

module tb_top;
    import bgc_pkg::*;

    // Kind code that the block must ignore, and the register index that it must ignore.
    localparam logic [1:0]           KIND_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] btn;
        t_event     code;
        logic [3:0] mask;
        logic       last;
    } t_gesture;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [1:0]        i_kind = KIND_TICK;
    logic [NOW_W-1:0]  i_now = '0;
    logic [3:0]        i_pin_levels = 4'hF;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [1:0]        o_button_index;
    logic [2:0]        o_event_code;
    logic [3:0]        o_pressed_mask;
    logic              o_last;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_LONG_PRESS;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    button_gesture_classifier_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_now          (i_now),
        .i_pin_levels   (i_pin_levels),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_button_index (o_button_index),
        .o_event_code   (o_event_code),
        .o_pressed_mask (o_pressed_mask),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Predicted copy of the timing registers and of each button's state.
    logic [31:0] cfg_long   = LONG_PRESS_RST;
    logic [31:0] cfg_hold   = HOLD_RST;
    logic [31:0] cfg_double = DOUBLE_RST;
    logic [3:0]  btn_down   = 4'h0;
    logic [31:0] t_press    [4] = '{default: '0};
    logic [31:0] t_mark     [4] = '{default: '0};
    logic [31:0] t_release  [4] = '{default: '0};
    logic [3:0]  armed      = 4'hF;

    t_gesture    pending_events[$];

    // Stimulus side: the running clock of the gesture source and the pins it holds.
    logic [31:0] clock_us = '0;
    logic [3:0]  tb_pins  = 4'hF;
    int unsigned tx_idle_pct = 12;
    int unsigned rx_idle_pct = 57;

    int unsigned mismatches     = 0;
    int unsigned beats_sent     = 0;
    int unsigned events_checked = 0;
    int unsigned settings_used  = 1;
    int unsigned seen_codes [7] = '{default: 0};

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall the event channel at the current idle rate.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic t_gesture gesture(input int b, input t_event c);
        t_gesture g;
        g.btn  = 2'(b);
        g.code = c;
        g.mask = btn_down;
        g.last = 1'b0;
        return g;
    endfunction

    // Work out the events that one accepted beat raises and queue them in order.
    task automatic predict_gestures(input logic [1:0] kind, input logic [31:0] now,
                                    input logic [3:0] pins);
        t_gesture    evs[$];
        logic [31:0] held;
        logic [31:0] gap;
        logic        pressed;
        int          i;
        case (kind)
            KIND_TICK: begin
                for (i = 0; i < 4; i++) begin
                    held = now - t_press[i];
                    gap  = now - t_mark[i];
                    if (btn_down[i] && held > cfg_long) begin
                        if (t_press[i] == t_mark[i]) begin
                            evs.push_back(gesture(i, EV_LONG_PRESS));
                            t_mark[i] = now;
                        end else if (gap > cfg_hold) begin
                            evs.push_back(gesture(i, EV_HOLD));
                            t_mark[i] = now;
                        end
                    end
                end
            end
            KIND_SAMPLE: begin
                for (i = 0; i < 4; i++) begin
                    pressed = !pins[i];
                    if (pressed != btn_down[i]) begin
                        btn_down[i] = pressed;
                        if (!pressed) begin
                            evs.push_back(gesture(i, EV_RELEASE));
                            held = now - t_press[i];
                            gap  = t_press[i] - t_release[i];
                            if (held > cfg_long) begin
                                evs.push_back(gesture(i, EV_LONG_CLICK));
                                armed[i] = 1'b0;
                            end else if (gap < cfg_double) begin
                                evs.push_back(gesture(i, EV_CLICK));
                                if (armed[i])
                                    evs.push_back(gesture(i, EV_DOUBLE));
                                armed[i] = 1'b0;
                            end else begin
                                armed[i] = 1'b1;
                                evs.push_back(gesture(i, EV_CLICK));
                            end
                            t_release[i] = now;
                        end else begin
                            evs.push_back(gesture(i, EV_PRESS));
                            t_press[i] = now;
                            t_mark[i]  = now;
                        end
                    end
                end
            end
            KIND_INIT: begin
                btn_down = ~pins;
                for (i = 0; i < 4; i++) begin
                    t_press[i]   = now;
                    t_mark[i]    = now;
                    t_release[i] = now;
                end
            end
            default: ;
        endcase
        if (evs.size() != 0)
            evs[evs.size() - 1].last = 1'b1;
        foreach (evs[k])
            pending_events.push_back(evs[k]);
    endtask

    // Send one beat after a random gap; valid stays high until the beat is taken.
    task automatic send_item(input logic [1:0] kind, input logic [31:0] now,
                             input logic [3:0] pins);
        int unsigned gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct && gap < 40)
            gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_now        <= now;
        i_pin_levels <= pins;
        do @(posedge i_clk); while (!o_ready);
        predict_gestures(kind, now, pins);
        if (kind != KIND_UNUSED)
            beats_sent++;
    endtask

    // Drop valid and hold until every predicted event has come out.
    task automatic wait_for_events_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_events.size() != 0);
    endtask

    // Write all timing registers, plus the unused index, while the block is idle.
    task automatic program_timing(input logic [31:0] long_us, input logic [31:0] hold_us,
                                  input logic [31:0] dbl_us);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [31:0]          val [4];
        int                   k;
        wait_for_events_drained();
        repeat (4) @(posedge i_clk);
        idx = '{CFG_LONG_PRESS, CFG_HOLD, CFG_DOUBLE, CFG_IDX_UNUSED};
        val = '{long_us, hold_us, dbl_us, $urandom};
        i_cfg_valid <= 1'b1;
        for (k = 0; k < 4; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                CFG_LONG_PRESS: cfg_long   = val[k];
                CFG_HOLD:       cfg_hold   = val[k];
                CFG_DOUBLE:     cfg_double = val[k];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Time advance: mostly near the thresholds, now and then a jump anywhere.
    function automatic logic [31:0] next_step(input int unsigned scale);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, scale / 4);
            4, 5, 6:    return $urandom_range(scale / 4, scale + scale / 8);
            7, 8:       return $urandom_range(scale, 3 * scale);
            default:    return $urandom;
        endcase
    endfunction

    // Random gestures: mostly one button changing at a time, with ticks between,
    // and some multi-button noise, re-inits and ignored beats.
    task automatic run_gestures(input int unsigned n_items, input int unsigned scale);
        int unsigned counted = 0;
        int unsigned pick;
        while (counted < n_items) begin
            if ($urandom_range(0, 99) < 3)
                wait_for_events_drained();
            pick = $urandom_range(0, 99);
            clock_us += next_step(scale);
            if (pick < 45) begin
                send_item(KIND_TICK, clock_us, 4'($urandom_range(0, 15)));
                counted++;
            end else if (pick < 90) begin
                if ($urandom_range(0, 4) != 0)
                    tb_pins ^= 4'(1 << $urandom_range(0, 3));
                else
                    tb_pins = 4'($urandom_range(0, 15));
                send_item(KIND_SAMPLE, clock_us, tb_pins);
                counted++;
            end else if (pick < 95) begin
                tb_pins = 4'($urandom_range(0, 15));
                send_item(KIND_INIT, clock_us, tb_pins);
                counted++;
            end else begin
                send_item(KIND_UNUSED, $urandom, 4'($urandom_range(0, 15)));
            end
        end
    endtask

    task automatic test_ignored_and_init();
        send_item(KIND_UNUSED, 32'hFFFF_FFFF, 4'h0);  // must change nothing
        send_item(KIND_INIT, 32'h0000_0000, 4'hF);
    endtask

    task automatic test_click_kinds();
        send_item(KIND_SAMPLE, 32'd100, 4'hE);
        send_item(KIND_SAMPLE, 32'd200_000, 4'hF);    // click then double click
        send_item(KIND_SAMPLE, 32'd300_000, 4'hE);
        send_item(KIND_SAMPLE, 32'd400_000, 4'hF);    // click only, double disarmed
        send_item(KIND_SAMPLE, 32'd2_000_000, 4'hE);
        send_item(KIND_SAMPLE, 32'd2_100_000, 4'hF);  // slow click re-arms double
    endtask

    task automatic test_long_press_and_hold();
        send_item(KIND_SAMPLE, 32'd2_200_000, 4'h0);  // all four pressed
        send_item(KIND_TICK, 32'd2_500_000, 4'h0);    // not held long enough yet
        send_item(KIND_TICK, 32'd3_200_001, 4'h5);    // long press on every button
        send_item(KIND_TICK, 32'd3_500_000, 4'hA);    // hold spacing not reached
        send_item(KIND_TICK, 32'd3_700_002, 4'hF);    // hold on every button
        wait_for_events_drained();
        send_item(KIND_SAMPLE, 32'd3_800_000, 4'hF);  // release with long click
    endtask

    task automatic test_full_burst();
        send_item(KIND_SAMPLE, 32'd5_000_000, 4'h0);
        send_item(KIND_SAMPLE, 32'd5_100_000, 4'hF);  // slow clicks re-arm
        send_item(KIND_SAMPLE, 32'd5_200_000, 4'h0);
        send_item(KIND_SAMPLE, 32'd5_300_000, 4'hF);  // twelve events in one beat
    endtask

    task automatic test_time_wrap();
        send_item(KIND_INIT, 32'hFFFF_FF00, 4'hF);
        send_item(KIND_SAMPLE, 32'h0000_0100, 4'h7);  // press across the wrap
        send_item(KIND_TICK, 32'h000F_4400, 4'hF);    // long press just past the limit
        send_item(KIND_SAMPLE, 32'h000F_5000, 4'hF);
        send_item(KIND_SAMPLE, 32'h0020_0000, 4'hA);
        send_item(KIND_INIT, 32'hFFFF_FFFF, 4'hF);
        clock_us = 32'hFFFF_FFFF;
        tb_pins  = 4'hF;
    endtask

    task automatic test_default_timing();
        run_gestures(70, 1_000_000);
    endtask

    task automatic test_short_timing();
        tx_idle_pct = 57;
        rx_idle_pct = 12;
        program_timing(32'd2000, 32'd700, 32'd1500);
        run_gestures(70, 2000);
    endtask

    task automatic test_zero_timing();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_timing('0, '0, '0);
        run_gestures(35, 1000);
    endtask

    task automatic test_max_timing();
        program_timing('1, '1, '1);
        run_gestures(35, 1_000_000);
    endtask

    task automatic test_random_timing();
        logic [31:0] long_us;
        long_us = $urandom_range(500, 5000);
        program_timing(long_us, $urandom_range(100, 2000), $urandom_range(100, 3000));
        run_gestures(50, long_us);
    endtask

    // Compare every event beat with the oldest prediction.
    always @(posedge i_clk) begin : event_checker
        t_gesture want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event: button %0d code %0d",
                                          o_button_index, o_event_code));
            end else begin
                want = pending_events.pop_front();
                events_checked++;
                seen_codes[want.code]++;
                if (o_button_index !== want.btn)
                    report_mismatch($sformatf("button_index %0d, predicted %0d",
                                              o_button_index, want.btn));
                if (o_event_code !== want.code)
                    report_mismatch($sformatf("event_code %0d, predicted %0d (button %0d)",
                                              o_event_code, want.code, want.btn));
                if (o_pressed_mask !== want.mask)
                    report_mismatch($sformatf("pressed_mask %h, predicted %h (button %0d)",
                                              o_pressed_mask, want.mask, want.btn));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %b, predicted %b (button %0d)",
                                              o_last, want.last, want.btn));
            end
        end
    end

    initial begin : run_limit
        #2_000_000;
        $display("button_gesture_classifier_top: mismatch");
        $finish;
    end

    initial begin : main_flow
        int unsigned guard;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ignored_and_init();
        test_click_kinds();
        test_long_press_and_hold();
        test_full_burst();
        test_time_wrap();
        test_default_timing();
        test_short_timing();
        test_zero_timing();
        test_max_timing();
        test_random_timing();

        // Drain the tail, then let the clock run on so that any stray events show.
        i_valid <= 1'b0;
        guard = 0;
        while (pending_events.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (16) @(posedge i_clk);
        if (pending_events.size() != 0)
            report_mismatch($sformatf("%0d predicted events never came out",
                                      pending_events.size()));

        $display("Ran %0d input beats under %0d timing settings; %0d events checked.",
                 beats_sent, settings_used, events_checked);
        $display("press %0d, release %0d, click %0d, double %0d, long click %0d, %s %0d, %s %0d",
                 seen_codes[EV_PRESS], seen_codes[EV_RELEASE], seen_codes[EV_CLICK],
                 seen_codes[EV_DOUBLE], seen_codes[EV_LONG_CLICK],
                 "long press", seen_codes[EV_LONG_PRESS], "hold", seen_codes[EV_HOLD]);
        if (mismatches == 0) begin
            $display("button_gesture_classifier_top: match");
        end else begin
            $display("button_gesture_classifier_top: mismatch");
        end
        $finish;
    end

endmodule
